[hw/rtl/mcos_pkg.sv]
// Shared constants and types of the multi-channel on/off sequencer.
package mcos_pkg;

    localparam int CHANNELS       = 4;
    localparam int DURATION_WIDTH = 16;

    // Fixed widths of the configuration registers and of the result fields.
    localparam int ENABLE_W  = 4;
    localparam int DUR_REG_W = 64;
    localparam int MASK_W    = 4;
    localparam int CFG_IDX_W = 2;

    // Duration registers are viewed through a zero-extended vector so that any
    // lane lying beyond the register reads as zero.
    localparam int LANE_BITS = (CHANNELS * DURATION_WIDTH > DUR_REG_W) ?
                               CHANNELS * DURATION_WIDTH : DUR_REG_W;
    localparam int EN_EXT_W  = (CHANNELS > ENABLE_W) ? CHANNELS : ENABLE_W;
    localparam int OUT_EXT_W = (CHANNELS > MASK_W) ? CHANNELS : MASK_W;

    typedef enum logic [1:0] {
        REQ_TICK        = 2'd0,
        REQ_TRIGGER     = 2'd1,
        REQ_TRIGGER_ALL = 2'd2,
        REQ_START       = 2'd3
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_ENABLE = 2'd0,
        CFG_CYCLIC_MODE    = 2'd1,
        CFG_ON_DURATIONS   = 2'd2,
        CFG_OFF_DURATIONS  = 2'd3
    } cfg_index_t;

    // Command seen by one channel for the request being applied.
    typedef struct packed {
        logic tick;
        logic trigger;
        logic trigger_all;
        logic start;
    } chan_cmd_t;

endpackage

[hw/rtl/mcos_channel.sv]
// One sequencer channel: output level, armed flag and wait counter.
module mcos_channel
    import mcos_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  chan_cmd_t                 cmd,
    input  logic                      enable,
    input  logic                      cyclic,
    input  logic [DURATION_WIDTH-1:0] on_time,
    input  logic [DURATION_WIDTH-1:0] off_time,
    output logic                      level,
    output logic                      armed
);

    logic [DURATION_WIDTH-1:0] wait_reg;
    logic [DURATION_WIDTH-1:0] wait_next;
    logic                      level_reg;
    logic                      level_next;
    logic                      armed_reg;
    logic                      armed_next;

    always_comb
    begin
        wait_next  = wait_reg;
        level_next = level_reg;
        armed_next = armed_reg;
        if (cmd.tick)
        begin
            if (armed_reg)
            begin
                if (wait_reg != '0)
                begin
                    wait_next = wait_reg - 1'b1;
                end
                else if (enable)
                begin
                    // A disabled channel parks at zero and stays armed.
                    if (level_reg)
                    begin
                        level_next = 1'b0;
                        if (cyclic)
                        begin
                            wait_next = off_time;
                        end
                        else
                        begin
                            armed_next = 1'b0;
                            wait_next  = '0;
                        end
                    end
                    else
                    begin
                        level_next = 1'b1;
                        wait_next  = on_time;
                    end
                end
            end
        end
        else if (cmd.trigger)
        begin
            armed_next = 1'b1;
            level_next = 1'b0;
            wait_next  = '0;
        end
        else if (cmd.trigger_all)
        begin
            armed_next = 1'b1;
            wait_next  = '0;
        end
        else if (cmd.start)
        begin
            armed_next = cyclic;
            level_next = 1'b0;
            wait_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg  <= '0;
            level_reg <= 1'b0;
            armed_reg <= 1'b0;
        end
        else if (step)
        begin
            wait_reg  <= wait_next;
            level_reg <= level_next;
            armed_reg <= armed_next;
        end
    end

    assign level = level_reg;
    assign armed = armed_reg;

endmodule

[hw/rtl/multi_channel_on_off_sequencer.sv]
// Top level of the multi-channel on/off sequencer with stream ports and a config port.
// Each request (a tick, a trigger of one channel, a trigger of all channels or a
// start) is taken into an input register and then applied to all channels in parallel;
// the channel state registers hold the result, so one request is accepted every cycle
// while the result is not stalled. A stalled result stops the input register only,
// which keeps accepting while it is empty.
// Configuration writes take effect at once and are meant for idle periods.
module multi_channel_on_off_sequencer
    import mcos_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [1:0] channel, rest zero
    input  logic [1:0]           s_tuser,   // [1:0] req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [3:0] output_levels, [7:4] armed_mask
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_REG_W-1:0] cfg_data
);

    logic [ENABLE_W-1:0]  enable_reg;
    logic                 cyclic_reg;
    logic [DUR_REG_W-1:0] on_reg;
    logic [DUR_REG_W-1:0] off_reg;

    logic                 in_valid_reg;
    req_type_t            req_reg;
    logic [1:0]           ch_reg;
    logic                 out_valid_reg;

    logic                 advance;
    logic                 step;
    chan_cmd_t            base_cmd;

    logic [LANE_BITS-1:0] on_ext;
    logic [LANE_BITS-1:0] off_ext;
    logic [EN_EXT_W-1:0]  enable_ext;
    logic [CHANNELS-1:0]  levels;
    logic [CHANNELS-1:0]  armed;
    logic [OUT_EXT_W-1:0] levels_ext;
    logic [OUT_EXT_W-1:0] armed_ext;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
            cyclic_reg <= 1'b0;
            on_reg     <= '0;
            off_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CHANNEL_ENABLE: enable_reg <= cfg_data[ENABLE_W-1:0];
                CFG_CYCLIC_MODE:    cyclic_reg <= cfg_data[0];
                CFG_ON_DURATIONS:   on_reg     <= cfg_data;
                CFG_OFF_DURATIONS:  off_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // The result register is free when empty or being drained this cycle.
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg <= req_type_t'(s_tuser);
            ch_reg  <= s_tdata[1:0];
        end
    end

    always_comb
    begin
        base_cmd = '0;
        unique case (req_reg)
            REQ_TICK:        base_cmd.tick        = 1'b1;
            REQ_TRIGGER:     base_cmd.trigger     = 1'b1;
            REQ_TRIGGER_ALL: base_cmd.trigger_all = 1'b1;
            REQ_START:       base_cmd.start       = 1'b1;
            default:         base_cmd = '0;
        endcase
    end

    assign on_ext     = LANE_BITS'(on_reg);
    assign off_ext    = LANE_BITS'(off_reg);
    assign enable_ext = EN_EXT_W'(enable_reg);

    for (genvar k = 0; k < CHANNELS; k++)
    begin : g_chan
        chan_cmd_t lane_cmd;

        always_comb
        begin
            lane_cmd         = base_cmd;
            // A trigger naming a channel that does not exist touches nothing.
            lane_cmd.trigger = base_cmd.trigger && (int'(ch_reg) == k);
        end

        mcos_channel u_channel (
            .clk      (clk),
            .rst_n    (rst_n),
            .step     (step),
            .cmd      (lane_cmd),
            .enable   (enable_ext[k]),
            .cyclic   (cyclic_reg),
            .on_time  (on_ext[k*DURATION_WIDTH +: DURATION_WIDTH]),
            .off_time (off_ext[k*DURATION_WIDTH +: DURATION_WIDTH]),
            .level    (levels[k]),
            .armed    (armed[k])
        );
    end

    assign levels_ext = OUT_EXT_W'(levels);
    assign armed_ext  = OUT_EXT_W'(armed);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {armed_ext[MASK_W-1:0], levels_ext[MASK_W-1:0]};

endmodule
